[hdl/alpl_pkg.sv]
// Shared constants for the arc length to parameter lookup block.
// Field widths, fixed point constants, op and result codes.
// No dependencies.
`default_nettype none

package alpl_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int DIST_W  = 32;
  localparam int PARAM_W = 17;
  localparam int FRAC_W  = 16;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int CODE_W  = 2;

  localparam logic [PARAM_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [PARAM_W-1:0] ZERO_Q16 = 17'h00000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CODE_W-1:0] CASE_INTERP = 2'd0;
  localparam logic [CODE_W-1:0] CASE_NEG    = 2'd1;
  localparam logic [CODE_W-1:0] CASE_END    = 2'd2;
  localparam logic [CODE_W-1:0] CASE_OTHER  = 2'd3;

endpackage

`default_nettype wire

[hdl/alpl_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Holds the breakpoint table. No dependencies.
`default_nettype none

module alpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/arc_length_to_param_lookup.sv]
// Top level of the arc length to parameter lookup: breakpoint table in RAM,
// span scan, serial divide and interpolation. Uses alpl_pkg and alpl_ram.
//
//   channel   signals                                         handshake
//   input     op, entry_index, distance, param_value          start && !busy
//   config    cfg_wr_data (entry_count)                       cfg_wr_en
//   result    param_out, span_found, case_code                done, one cycle
//
// A write item gives no result; busy stays low.
// A query scans the table one entry per cycle out of the RAM read port
// (only the entries in use, at most TABLE_DEPTH), then runs a 16 step
// restoring divide, one multiply and one add; done is high in the first
// cycle with busy low again.
// A query with entry_count 0 answers in the next cycle without raising busy.
// rst is synchronous; the table contents are not cleared.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none

module arc_length_to_param_lookup #(
  parameter int TABLE_DEPTH = alpl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               op,
  input  wire logic [alpl_pkg::INDEX_W-1:0]       entry_index,
  input  wire logic signed [alpl_pkg::DIST_W-1:0] distance,
  input  wire logic [alpl_pkg::PARAM_W-1:0]       param_value,
  input  wire logic                               cfg_wr_en,
  input  wire logic [alpl_pkg::COUNT_W-1:0]       cfg_wr_data,
  output logic                                    done,
  output logic      [alpl_pkg::PARAM_W-1:0]       param_out,
  output logic      [alpl_pkg::INDEX_W-1:0]       span_found,
  output logic      [alpl_pkg::CODE_W-1:0]        case_code
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int DW    = alpl_pkg::DIST_W;
  localparam int PW    = alpl_pkg::PARAM_W;
  localparam int FW    = alpl_pkg::FRAC_W;
  localparam int ENT_W = DW + PW;
  localparam int CNT_W = $clog2(FW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                 state;
  logic [alpl_pkg::COUNT_W-1:0] entry_count;
  logic [IDX_W-1:0]           rd_idx;
  logic [IDX_W-1:0]           last_idx;
  logic signed [DW-1:0]       query_dist;
  logic signed [DW-1:0]       prev_dist;
  logic [PW-1:0]              prev_param;
  logic [PW-1:0]              p0;
  logic [PW-1:0]              p1;
  logic [DW-1:0]              rem;
  logic [DW-1:0]              span;
  logic [FW-1:0]              quot;
  logic [CNT_W-1:0]           div_cnt;
  logic [alpl_pkg::INDEX_W-1:0] span_idx;
  logic signed [PW+FW+1:0]    prod;

  logic                       wr_en;
  logic [IDX_W-1:0]           raddr;
  logic [ENT_W-1:0]           wdata;
  logic [ENT_W-1:0]           rdata;
  logic [PW-1:0]              param_sat;
  logic signed [DW-1:0]       cur_dist;
  logic [PW-1:0]              cur_param;
  logic                       hit;
  logic [alpl_pkg::CODE_W-1:0] end_code;
  logic [PW-1:0]              end_param;
  logic [DW:0]                rem_shift;
  logic                       rem_ge;
  logic signed [PW:0]         p_diff;
  logic signed [PW+2:0]       interp_sum;
  int                         lim;

  assign busy = (state != ST_IDLE);

  // Table write: ignored past the table depth
  assign param_sat = (param_value > alpl_pkg::ONE_Q16) ? alpl_pkg::ONE_Q16 : param_value;
  assign wr_en = start && !busy && (op == alpl_pkg::OP_WRITE) &&
                 (32'(entry_index) < 32'(TABLE_DEPTH));
  assign wdata = {distance, param_sat};
  assign raddr = (state == ST_SCAN) ? rd_idx + IDX_W'(1) : '0;

  alpl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(IDX_W'(entry_index)),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cur_dist  = rdata[ENT_W-1:PW];
  assign cur_param = rdata[PW-1:0];
  assign hit = (query_dist >= prev_dist) && (query_dist < cur_dist);

  // No span matched: decide against the last entry's distance
  always_comb begin
    if (query_dist[DW-1]) begin
      end_code  = alpl_pkg::CASE_NEG;
      end_param = alpl_pkg::ZERO_Q16;
    end else if (query_dist >= cur_dist) begin
      end_code  = alpl_pkg::CASE_END;
      end_param = alpl_pkg::ONE_Q16;
    end else begin
      end_code  = alpl_pkg::CASE_OTHER;
      end_param = alpl_pkg::ZERO_Q16;
    end
  end

  assign lim = (32'(entry_count) > 32'(TABLE_DEPTH)) ? TABLE_DEPTH : 32'(entry_count);

  // One restoring divide step; rem stays below span
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, span});

  assign p_diff     = $signed({1'b0, p1}) - $signed({1'b0, p0});
  assign interp_sum = $signed({3'b000, p0}) + (PW+3)'(prod >>> FW);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start && op == alpl_pkg::OP_QUERY) begin
            if (entry_count == '0) begin
              param_out  <= alpl_pkg::ZERO_Q16;
              span_found <= '0;
              case_code  <= distance[DW-1] ? alpl_pkg::CASE_NEG : alpl_pkg::CASE_OTHER;
              done       <= 1'b1;
            end else begin
              query_dist <= distance;
              last_idx   <= IDX_W'(lim - 1);
              rd_idx     <= '0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_idx == '0) begin
            prev_dist  <= cur_dist;
            prev_param <= cur_param;
            if (last_idx == '0) begin
              param_out  <= end_param;
              span_found <= '0;
              case_code  <= end_code;
              done       <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end else if (hit) begin
            rem      <= query_dist - prev_dist;
            span     <= cur_dist - prev_dist;
            p0       <= prev_param;
            p1       <= cur_param;
            span_idx <= alpl_pkg::INDEX_W'(32'(rd_idx) - 1);
            div_cnt  <= '0;
            state    <= ST_DIV;
          end else if (rd_idx == last_idx) begin
            param_out  <= end_param;
            span_found <= '0;
            case_code  <= end_code;
            done       <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            // advance: current entry becomes the span start
            prev_dist  <= cur_dist;
            prev_param <= cur_param;
            rd_idx     <= rd_idx + IDX_W'(1);
          end
        end
        ST_DIV: begin
          rem     <= rem_ge ? DW'(rem_shift - {1'b0, span}) : rem_shift[DW-1:0];
          quot    <= {quot[FW-2:0], rem_ge};
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(FW - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= p_diff * $signed({1'b0, quot});
          state <= ST_FIN;
        end
        ST_FIN: begin
          param_out  <= interp_sum[PW-1:0];
          span_found <= span_idx;
          case_code  <= alpl_pkg::CASE_INTERP;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == alpl_pkg::OP_WRITE) |=> !done)
    else $error("write item produced a result");

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != CNT_W'(FW - 1)) |=> state == ST_DIV)
    else $error("divide left early");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> rd_idx <= last_idx)
    else $error("scan ran past last entry");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_arc_length_to_param_lookup.sv]
// Testbench for arc_length_to_param_lookup: breakpoint table writes and distance queries.
// A scoreboard class mirrors the table and predicts every query result.
// Depends on alpl_pkg and the block's RTL.

module tb_arc_length_to_param_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH_DEF = alpl_pkg::TABLE_DEPTH_DEF;
  localparam int DIST_W  = alpl_pkg::DIST_W;
  localparam int PARAM_W = alpl_pkg::PARAM_W;
  localparam int COUNT_W = alpl_pkg::COUNT_W;
  localparam int INDEX_W = alpl_pkg::INDEX_W;
  localparam int CODE_W  = alpl_pkg::CODE_W;

  localparam logic [PARAM_W-1:0] ONE_Q16  = alpl_pkg::ONE_Q16;
  localparam logic [PARAM_W-1:0] ZERO_Q16 = alpl_pkg::ZERO_Q16;

  localparam logic OP_WRITE = alpl_pkg::OP_WRITE;
  localparam logic OP_QUERY = alpl_pkg::OP_QUERY;

  localparam logic [CODE_W-1:0] CASE_INTERP = alpl_pkg::CASE_INTERP;
  localparam logic [CODE_W-1:0] CASE_NEG    = alpl_pkg::CASE_NEG;
  localparam logic [CODE_W-1:0] CASE_END    = alpl_pkg::CASE_END;
  localparam logic [CODE_W-1:0] CASE_OTHER  = alpl_pkg::CASE_OTHER;

  localparam longint D_MIN = -64'sh8000_0000;
  localparam longint D_MAX = 64'sh7FFF_FFFF;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEM_TARGET = 1200;

  typedef struct packed {
    logic [PARAM_W-1:0] param;
    logic [INDEX_W-1:0] span;
    logic [CODE_W-1:0]  code;
  } lookup_result_t;

  class param_lookup_model;
    logic signed [DIST_W-1:0] brk_dist [TABLE_DEPTH_DEF];
    logic [PARAM_W-1:0]       brk_param [TABLE_DEPTH_DEF];
    int unsigned              active_count;
    lookup_result_t           expected_lookups [$];
    int unsigned              errors;

    function new();
      for (int k = 0; k < TABLE_DEPTH_DEF; k++) begin
        brk_dist[k] = '0;
        brk_param[k] = '0;
      end
      active_count = 0;
      errors = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      active_count = value;
    endfunction

    // Apply a write to the table, or queue the answer of a query.
    function void note_item(logic op_i, logic [INDEX_W-1:0] idx,
                            logic signed [DIST_W-1:0] dist_i, logic [PARAM_W-1:0] pv);
      lookup_result_t r;
      int n;
      bit hit;
      longint lo_d, hi_d, dq;
      logic [63:0] span, off, frac, val;
      if (op_i == OP_WRITE) begin
        brk_dist[idx] = dist_i;
        brk_param[idx] = (pv > ONE_Q16) ? ONE_Q16 : pv;
        return;
      end
      n = (active_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : active_count;
      dq = dist_i;
      hit = 1'b0;
      r.param = ZERO_Q16;
      r.span = '0;
      r.code = CASE_OTHER;
      for (int i = 0; i + 1 < n; i++) begin
        lo_d = brk_dist[i];
        hi_d = brk_dist[i + 1];
        if (!hit && dq >= lo_d && dq < hi_d) begin
          span = 64'(hi_d - lo_d);
          off = 64'(dq - lo_d);
          frac = (off << 16) / span;
          val = (64'(brk_param[i]) * (64'd65536 - frac) + 64'(brk_param[i + 1]) * frac) >> 16;
          r.param = val[PARAM_W-1:0];
          r.span = INDEX_W'(i);
          r.code = CASE_INTERP;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (dq < 0) begin
          r.code = CASE_NEG;
        end else if (n > 0 && dq >= longint'(brk_dist[n - 1])) begin
          r.param = ONE_Q16;
          r.code = CASE_END;
        end
      end
      expected_lookups = {expected_lookups, r};
    endfunction

    function void check_result(logic [PARAM_W-1:0] p, logic [INDEX_W-1:0] s,
                               logic [CODE_W-1:0] c);
      lookup_result_t e;
      if (expected_lookups.size() == 0) begin
        $error("unexpected result: param_out %0d span_found %0d case_code %0d", p, s, c);
        errors++;
        return;
      end
      e = expected_lookups.pop_front();
      if (p !== e.param) begin
        $error("param_out mismatch: expected %0d, actual %0d", e.param, p);
        errors++;
      end
      if (s !== e.span) begin
        $error("span_found mismatch: expected %0d, actual %0d", e.span, s);
        errors++;
      end
      if (c !== e.code) begin
        $error("case_code mismatch: expected %0d, actual %0d", e.code, c);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = OP_WRITE;
  logic [INDEX_W-1:0] entry_index = '0;
  logic signed [DIST_W-1:0] distance = '0;
  logic [PARAM_W-1:0] param_value = '0;
  logic cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic busy;
  logic done;
  logic [PARAM_W-1:0] param_out;
  logic [INDEX_W-1:0] span_found;
  logic [CODE_W-1:0] case_code;

  param_lookup_model sb = new();
  bit steady_phase = 1'b0;
  int unsigned items_sent = 0;

  arc_length_to_param_lookup DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .entry_index(entry_index),
    .distance(distance),
    .param_value(param_value),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .done(done),
    .param_out(param_out),
    .span_found(span_found),
    .case_code(case_code)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Sample at the edge: all values seen here are the ones before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(param_out, span_found, case_code);
      if (start && !busy) sb.note_item(op, entry_index, distance, param_value);
    end
  end

  // Leaves start high; the next call or an idle stretch decides what follows.
  task automatic send_item(logic o, logic [INDEX_W-1:0] idx,
                           logic signed [DIST_W-1:0] d, logic [PARAM_W-1:0] pv);
    int unsigned gap;
    gap = 0;
    if (!steady_phase && $urandom_range(1, 0) == 0)
      gap = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 10) : $urandom_range(3, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    entry_index <= idx;
    distance <= d;
    param_value <= pv;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_query(logic signed [DIST_W-1:0] d);
    send_item(OP_QUERY, INDEX_W'($urandom), d, PARAM_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (sb.expected_lookups.size() != 0) @(negedge clk);
  endtask

  task automatic set_count(logic [COUNT_W-1:0] value);
    start <= 1'b0;
    wait_drained();
    // Writes give no result, so let any work still in flight finish.
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_count(value);
  endtask

  function automatic logic [PARAM_W-1:0] pick_param();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return PARAM_W'($urandom_range(131071, 65537));
    if (sel == 1) return ($urandom_range(1, 0) == 0) ? ZERO_Q16 : ONE_Q16;
    return PARAM_W'($urandom_range(65536, 0));
  endfunction

  // Fill entries 0..n-1 with rising distances; messy tables get flat and falling spans.
  task automatic load_table(int unsigned n, bit messy);
    longint step_max, pos, step;
    case ($urandom_range(4, 0))
      0: step_max = 4;
      1: step_max = 256;
      2: step_max = 65536;
      3: step_max = 64'd1 << 20;
      default: step_max = 64'd1 << 25;
    endcase
    if ($urandom_range(9, 0) == 0) pos = D_MIN;
    else pos = D_MIN + longint'({$urandom, $urandom} % 64'(D_MAX - D_MIN - n * step_max + 1));
    for (int k = 0; k < n; k++) begin
      send_item(OP_WRITE, INDEX_W'(k), pos[DIST_W-1:0], pick_param());
      step = $urandom_range(step_max, 1);
      if (messy && $urandom_range(7, 0) == 0)
        step = ($urandom_range(1, 0) == 0) ? 0 : -longint'($urandom_range(step_max, 0));
      pos = pos + step;
      if (pos > D_MAX) pos = D_MAX;
      if (pos < D_MIN) pos = D_MIN;
    end
  endtask

  // Aim most queries inside spans, at breakpoints and around both ends.
  function automatic logic signed [DIST_W-1:0] pick_distance(int unsigned n);
    longint lo_d, hi_d, v;
    int unsigned i, sel;
    sel = $urandom_range(99, 0);
    v = $signed($urandom);
    if (n != 0) begin
      i = (n > 1) ? $urandom_range(n - 2, 0) : 0;
      lo_d = sb.brk_dist[i];
      hi_d = sb.brk_dist[(n > 1) ? i + 1 : 0];
      if (sel < 55) begin
        if (hi_d > lo_d) v = lo_d + longint'({$urandom, $urandom} % 64'(hi_d - lo_d));
        else v = lo_d;
      end else if (sel < 65) begin
        v = lo_d;
      end else if (sel < 70) begin
        v = hi_d - 1;
      end else if (sel < 80) begin
        v = longint'(sb.brk_dist[n - 1]) + $urandom_range(2, 0);
      end else if (sel < 88) begin
        v = longint'(sb.brk_dist[0]) - $urandom_range(3, 1);
      end
    end
    if (v > D_MAX) v = D_MAX;
    if (v < D_MIN) v = D_MIN;
    return v[DIST_W-1:0];
  endfunction

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned cnt, n, guard;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty table.
    set_count(0);
    send_query(32'sh8000_0000);
    send_query(-32'sd1);
    send_query(32'sd0);
    send_query(32'sh7FFF_FFFF);

    // Define every entry once, then set up the widest span.
    load_table(TABLE_DEPTH_DEF, 1'b0);
    send_item(OP_WRITE, 6'd0, 32'sh8000_0000, ZERO_Q16);
    send_item(OP_WRITE, 6'd1, 32'sh7FFF_FFFF, 17'h1FFFF);
    send_item(OP_WRITE, 6'd2, 32'sd0, 17'd1000);
    set_count(2);
    send_query(32'sh8000_0000);
    send_query(32'sd0);
    send_query(32'sh7FFF_FFFE);
    send_query(32'sh7FFF_FFFF);

    // Falling span never matches.
    set_count(3);
    send_query(32'sh7FFF_FFFF);
    send_query(32'sd5);

    // Positive table start: below it, negative, inside, at end.
    send_item(OP_WRITE, 6'd0, 32'sd10 <<< 16, 17'd5);
    send_item(OP_WRITE, 6'd1, 32'sd20 <<< 16, 17'd60000);
    set_count(2);
    send_query(32'sd5 <<< 16);
    send_query(-32'sd5);
    send_query(32'sd15 <<< 16);
    send_query(32'sd20 <<< 16);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(19, 0))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 2;
        3: cnt = TABLE_DEPTH_DEF;
        4: cnt = ($urandom_range(1, 0) == 0) ? 127 : $urandom_range(126, 65);
        5, 6: cnt = $urandom_range(64, 17);
        default: cnt = $urandom_range(16, 2);
      endcase
      set_count(COUNT_W'(cnt));
      n = (cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cnt;
      steady_phase = ($urandom_range(3, 0) == 0);
      load_table(n, $urandom_range(3, 0) == 0);
      repeat ($urandom_range(100, 40)) begin
        if ($urandom_range(9, 0) == 0)
          send_item(OP_WRITE, INDEX_W'($urandom), $signed($urandom), PARAM_W'($urandom));
        else
          send_query(pick_distance(n));
      end
    end

    start <= 1'b0;
    @(negedge clk);
    guard = 0;
    while (sb.expected_lookups.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_lookups.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_lookups.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/alpl_pkg.sv
hdl/alpl_ram.sv
hdl/arc_length_to_param_lookup.sv
tb/sv/tb_arc_length_to_param_lookup.sv
